@@ rtl/lfps_pkg.sv @@
package lfps_pkg;

  // fixed-point gain format
  localparam int GAIN_FRAC_BITS = 8;

  // field widths
  localparam int SENSORS    = 6;
  localparam int ERR_W      = 6;
  localparam int INTEG_W    = 11;
  localparam int ACC_W      = INTEG_W + 1;
  localparam int DERIV_W    = ERR_W + 1;
  localparam int GAIN_W     = 12;
  localparam int SPEED_W    = 8;
  localparam int LIMIT_W    = 10;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  // product and sum widths, gains carry one extra sign bit
  localparam int P_PROD_W = GAIN_W + 1 + ERR_W;
  localparam int I_PROD_W = GAIN_W + 1 + INTEG_W;
  localparam int D_PROD_W = GAIN_W + 1 + DERIV_W;
  localparam int SUM_W    = I_PROD_W + 1;
  localparam int CORR_W   = SUM_W - GAIN_FRAC_BITS;
  localparam int SPD_W    = ((CORR_W > SPEED_W) ? CORR_W : SPEED_W) + 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CRUISE_SPEED = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_MAX    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_LIMIT  = 3'd5;

  // register reset values
  localparam logic [GAIN_W-1:0]  RST_PROP_GAIN    = 12'd128;
  localparam logic [GAIN_W-1:0]  RST_INTEG_GAIN   = 12'd0;
  localparam logic [GAIN_W-1:0]  RST_DERIV_GAIN   = 12'd51;
  localparam logic [SPEED_W-1:0] RST_CRUISE_SPEED = 8'd20;
  localparam logic [SPEED_W-1:0] RST_SPEED_MAX    = 8'd30;
  localparam logic [LIMIT_W-1:0] RST_INTEG_LIMIT  = 10'd100;

  // sensor weights, left to right
  localparam logic signed [ERR_W-1:0] SENSOR_WEIGHT [SENSORS] =
    '{-6'sd10, -6'sd5, -6'sd1, 6'sd1, 6'sd5, 6'sd10};

  typedef struct packed {
    logic [GAIN_W-1:0]  prop_gain;
    logic [GAIN_W-1:0]  integ_gain;
    logic [GAIN_W-1:0]  deriv_gain;
    logic [SPEED_W-1:0] cruise_speed;
    logic [SPEED_W-1:0] speed_max;
    logic [LIMIT_W-1:0] integ_limit;
  } cfg_t;

  typedef struct packed {
    logic [ERR_W-1:0]    err;
    logic [P_PROD_W-1:0] p_prod;
    logic [I_PROD_W-1:0] i_prod;
    logic [D_PROD_W-1:0] d_prod;
  } prod_t;

endpackage

@@ rtl/lfps_cfg_regs.sv @@
module lfps_cfg_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [lfps_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [lfps_pkg::CFG_DATA_W-1:0]  cfg_data,
  output lfps_pkg::cfg_t                   cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.prop_gain    <= lfps_pkg::RST_PROP_GAIN;
      cfg.integ_gain   <= lfps_pkg::RST_INTEG_GAIN;
      cfg.deriv_gain   <= lfps_pkg::RST_DERIV_GAIN;
      cfg.cruise_speed <= lfps_pkg::RST_CRUISE_SPEED;
      cfg.speed_max    <= lfps_pkg::RST_SPEED_MAX;
      cfg.integ_limit  <= lfps_pkg::RST_INTEG_LIMIT;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        lfps_pkg::REG_PROP_GAIN:    cfg.prop_gain    <= cfg_data[lfps_pkg::GAIN_W-1:0];
        lfps_pkg::REG_INTEG_GAIN:   cfg.integ_gain   <= cfg_data[lfps_pkg::GAIN_W-1:0];
        lfps_pkg::REG_DERIV_GAIN:   cfg.deriv_gain   <= cfg_data[lfps_pkg::GAIN_W-1:0];
        lfps_pkg::REG_CRUISE_SPEED: cfg.cruise_speed <= cfg_data[lfps_pkg::SPEED_W-1:0];
        lfps_pkg::REG_SPEED_MAX:    cfg.speed_max    <= cfg_data[lfps_pkg::SPEED_W-1:0];
        lfps_pkg::REG_INTEG_LIMIT:  cfg.integ_limit  <= cfg_data[lfps_pkg::LIMIT_W-1:0];
        default: ;  // unmapped index, dropped
      endcase
    end
  end

endmodule

@@ rtl/lfps_err_stage.sv @@
module lfps_err_stage (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [lfps_pkg::SENSORS-1:0]    sensor_bits,
  input  lfps_pkg::cfg_t                  cfg,
  input  logic                            prod_ready,
  output logic                            prod_valid,
  output lfps_pkg::prod_t                 prod
);

  logic                                 s0_valid;
  logic [lfps_pkg::SENSORS-1:0]         s0_bits;
  logic                                 advance;

  logic signed [lfps_pkg::ERR_W-1:0]    prev_error;
  logic signed [lfps_pkg::INTEG_W-1:0]  integ_acc;

  logic signed [lfps_pkg::ERR_W-1:0]    err_raw;
  logic signed [lfps_pkg::ERR_W-1:0]    err;
  logic signed [lfps_pkg::ACC_W-1:0]    integ_sum;
  logic signed [lfps_pkg::ACC_W-1:0]    lim;
  logic signed [lfps_pkg::ACC_W-1:0]    lim_neg;
  logic signed [lfps_pkg::INTEG_W-1:0]  integ_next;
  logic signed [lfps_pkg::DERIV_W-1:0]  deriv;
  logic signed [lfps_pkg::GAIN_W:0]     pg;
  logic signed [lfps_pkg::GAIN_W:0]     ig;
  logic signed [lfps_pkg::GAIN_W:0]     dg;
  logic signed [lfps_pkg::P_PROD_W-1:0] p_prod;
  logic signed [lfps_pkg::I_PROD_W-1:0] i_prod;
  logic signed [lfps_pkg::D_PROD_W-1:0] d_prod;

  assign advance  = s0_valid && (!prod_valid || prod_ready);
  assign in_ready = !s0_valid || advance;

  always_comb begin
    err_raw = '0;
    for (int i = 0; i < lfps_pkg::SENSORS; i++) begin
      if (s0_bits[i]) err_raw = err_raw + lfps_pkg::SENSOR_WEIGHT[i];
    end
    // no line seen: hold the last error
    err = (s0_bits == '0) ? prev_error : err_raw;

    integ_sum = {integ_acc[lfps_pkg::INTEG_W-1], integ_acc}
              + {{(lfps_pkg::ACC_W - lfps_pkg::ERR_W){err[lfps_pkg::ERR_W-1]}}, err};
    lim     = {{(lfps_pkg::ACC_W - lfps_pkg::LIMIT_W){1'b0}}, cfg.integ_limit};
    lim_neg = -lim;
    if (integ_sum < lim_neg)  integ_next = lim_neg[lfps_pkg::INTEG_W-1:0];
    else if (integ_sum > lim) integ_next = lim[lfps_pkg::INTEG_W-1:0];
    else                      integ_next = integ_sum[lfps_pkg::INTEG_W-1:0];

    deriv = {err[lfps_pkg::ERR_W-1], err} - {prev_error[lfps_pkg::ERR_W-1], prev_error};

    pg = {1'b0, cfg.prop_gain};
    ig = {1'b0, cfg.integ_gain};
    dg = {1'b0, cfg.deriv_gain};
    p_prod = lfps_pkg::P_PROD_W'(pg) * lfps_pkg::P_PROD_W'(err);
    i_prod = lfps_pkg::I_PROD_W'(ig) * lfps_pkg::I_PROD_W'(integ_next);
    d_prod = lfps_pkg::D_PROD_W'(dg) * lfps_pkg::D_PROD_W'(deriv);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid   <= 1'b0;
      prod_valid <= 1'b0;
      prev_error <= '0;
      integ_acc  <= '0;
    end else begin
      if (in_ready) s0_valid <= in_valid;
      if (!prod_valid || prod_ready) prod_valid <= s0_valid;
      if (advance) begin
        prev_error <= err;
        integ_acc  <= integ_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) s0_bits <= sensor_bits;
    if (advance) begin
      prod.err    <= err;
      prod.p_prod <= p_prod;
      prod.i_prod <= i_prod;
      prod.d_prod <= d_prod;
    end
  end

endmodule

@@ rtl/lfps_speed_stage.sv @@
module lfps_speed_stage (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                prod_valid,
  output logic                                prod_ready,
  input  lfps_pkg::prod_t                     prod,
  input  lfps_pkg::cfg_t                      cfg,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [lfps_pkg::SPEED_W-1:0]        left_drive,
  output logic [lfps_pkg::SPEED_W-1:0]        right_drive,
  output logic signed [lfps_pkg::ERR_W-1:0]   line_error
);

  logic signed [lfps_pkg::SUM_W-1:0]  sum;
  logic [lfps_pkg::SUM_W-1:0]         mag;
  logic [lfps_pkg::CORR_W-1:0]        corr_mag;
  logic signed [lfps_pkg::SPD_W-1:0]  corr;
  logic signed [lfps_pkg::SPD_W-1:0]  cruise_ext;
  logic signed [lfps_pkg::SPD_W-1:0]  max_ext;
  logic [lfps_pkg::SPEED_W-1:0]       left_next;
  logic [lfps_pkg::SPEED_W-1:0]       right_next;

  function automatic logic [lfps_pkg::SPEED_W-1:0] sat_speed(
    input logic signed [lfps_pkg::SPD_W-1:0] v,
    input logic signed [lfps_pkg::SPD_W-1:0] hi
  );
    logic [lfps_pkg::SPEED_W-1:0] r;
    if (v[lfps_pkg::SPD_W-1]) r = '0;
    else if (v > hi)          r = hi[lfps_pkg::SPEED_W-1:0];
    else                      r = v[lfps_pkg::SPEED_W-1:0];
    return r;
  endfunction

  assign prod_ready = !out_valid || out_ready;

  always_comb begin
    sum = {{(lfps_pkg::SUM_W - lfps_pkg::P_PROD_W){prod.p_prod[lfps_pkg::P_PROD_W-1]}},
           prod.p_prod}
        + {{(lfps_pkg::SUM_W - lfps_pkg::I_PROD_W){prod.i_prod[lfps_pkg::I_PROD_W-1]}},
           prod.i_prod}
        + {{(lfps_pkg::SUM_W - lfps_pkg::D_PROD_W){prod.d_prod[lfps_pkg::D_PROD_W-1]}},
           prod.d_prod};
    // truncate toward zero: shift the magnitude, then restore the sign
    mag      = sum[lfps_pkg::SUM_W-1] ? -sum : sum;
    corr_mag = mag[lfps_pkg::SUM_W-1:lfps_pkg::GAIN_FRAC_BITS];
    corr     = {{(lfps_pkg::SPD_W - lfps_pkg::CORR_W){1'b0}}, corr_mag};
    if (sum[lfps_pkg::SUM_W-1]) corr = -corr;
    cruise_ext = {{(lfps_pkg::SPD_W - lfps_pkg::SPEED_W){1'b0}}, cfg.cruise_speed};
    max_ext    = {{(lfps_pkg::SPD_W - lfps_pkg::SPEED_W){1'b0}}, cfg.speed_max};
    left_next  = sat_speed(cruise_ext - corr, max_ext);
    right_next = sat_speed(cruise_ext + corr, max_ext);
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (prod_ready) out_valid <= prod_valid;
  end

  always_ff @(posedge clk) begin
    if (prod_valid && prod_ready) begin
      left_drive  <= left_next;
      right_drive <= right_next;
      line_error  <= prod.err;
    end
  end

endmodule

@@ rtl/line_follow_pid_steering_top.sv @@
// channel | direction | handshake              | payload
// in      | input     | in_valid / in_ready    | sensor_bits[5:0]
// out     | output    | out_valid / out_ready  | left_drive, right_drive, line_error
// cfg     | input     | cfg_valid / cfg_ready  | cfg_index[2:0], cfg_data[11:0]
//
// one sensor tick per cycle sustained while out_ready is high; each stage below is registered
// stages: input register, error/integral/product register, speed result register
// rst (synchronous) empties the pipeline, zeroes prev error and integral, loads reg defaults
// an output stall backs up stage by stage; in_ready drops only once all three are full
// cfg_ready is always high; writes to unmapped indexes are dropped
module line_follow_pid_steering_top (
  input  logic                                clk,
  input  logic                                rst,
  // sensor tick channel
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [lfps_pkg::SENSORS-1:0]        sensor_bits,
  // steering result channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [lfps_pkg::SPEED_W-1:0]        left_drive,
  output logic [lfps_pkg::SPEED_W-1:0]        right_drive,
  output logic signed [lfps_pkg::ERR_W-1:0]   line_error,
  // register write channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [lfps_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lfps_pkg::CFG_DATA_W-1:0]     cfg_data
);

  lfps_pkg::cfg_t   cfg;
  lfps_pkg::prod_t  prod;
  logic             prod_valid;
  logic             prod_ready;

  // gains, speeds and integral limit
  lfps_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // weighted error, held error on line loss, clamped integral, derivative,
  // and the three gain products; prev error and integral update once per transfer
  lfps_err_stage u_err (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .sensor_bits (sensor_bits),
    .cfg         (cfg),
    .prod_ready  (prod_ready),
    .prod_valid  (prod_valid),
    .prod        (prod)
  );

  // pid sum, truncation toward zero, left/right saturation, result register
  lfps_speed_stage u_speed (
    .clk         (clk),
    .rst         (rst),
    .prod_valid  (prod_valid),
    .prod_ready  (prod_ready),
    .prod        (prod),
    .cfg         (cfg),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .left_drive  (left_drive),
    .right_drive (right_drive),
    .line_error  (line_error)
  );

endmodule

@@ rtl/lfps_checker.sv @@
module lfps_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic [lfps_pkg::SPEED_W-1:0]        left_drive,
  input logic [lfps_pkg::SPEED_W-1:0]        right_drive,
  input logic signed [lfps_pkg::ERR_W-1:0]   line_error,
  input logic                                cfg_valid,
  input logic                                cfg_ready
);

  // stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(left_drive)
      && $stable(right_drive) && $stable(line_error))
    else $error("result changed while stalled");

  // weighted error never leaves the reachable range
  a_err_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (line_error >= -16) && (line_error <= 16))
    else $error("line error out of range");

  // reset empties the pipeline
  a_rst_empty: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("pipeline not empty after reset");

  // an empty pipeline never stalls the input
  a_no_stall: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input stalled with no result pending");

  // register writes are never held off
  a_cfg_open: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("register write held off");

endmodule

bind line_follow_pid_steering_top lfps_checker u_lfps_checker (.*);
